[sv/sha_pkg.sv]
// shared types and constants for the sha-256 stream hasher
// initial hash values, round constant table, core command and status structs
// no dependencies
package sha_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 4;
    localparam int ROUND_W = 6;
    localparam int LEN_W   = 64;

    typedef logic [7:0][WORD_W-1:0] hash_t;
    typedef logic [15:0][WORD_W-1:0] window_t;

    localparam hash_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    typedef struct packed {
        logic              push;
        logic [WORD_W-1:0] word;
        logic              init_chain;
    } core_cmd_t;

    typedef struct packed {
        logic               busy;
        logic [COUNT_W-1:0] count;
    } core_stat_t;

    function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] t);
        logic [WORD_W-1:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

[sv/sha_core.sv]
// sha-256 compression core: 16-word sliding schedule window, one round per cycle
// holds the chaining value and the block word count; depends on sha_pkg
module sha_core
    import sha_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  core_cmd_t  cmd,
    output core_stat_t stat,
    output hash_t      digest
);

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_ROUND = 3'b010,
        C_FINAL = 3'b100
    } core_state_t;

    core_state_t        state_reg, state_next;
    logic [ROUND_W-1:0] rnd_reg, rnd_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    hash_t              chain_reg, chain_next;
    hash_t              v_reg, v_next;
    window_t            win_reg, win_next;

    logic [WORD_W-1:0] sched_w, t1, t2;

    function automatic logic [WORD_W-1:0] bsig0(input logic [WORD_W-1:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [WORD_W-1:0] bsig1(input logic [WORD_W-1:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [WORD_W-1:0] ssig0(input logic [WORD_W-1:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [WORD_W-1:0] ssig1(input logic [WORD_W-1:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    assign sched_w = ssig1(win_reg[14]) + win_reg[9] + ssig0(win_reg[1]) + win_reg[0];
    assign t1 = v_reg[7] + bsig1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + round_k(rnd_reg) + win_reg[0];
    assign t2 = bsig0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        count_next = count_reg;
        chain_next = chain_reg;
        v_next     = v_reg;
        win_next   = win_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (cmd.init_chain) begin
                    chain_next = INIT_HASH;
                end
                if (cmd.push) begin
                    win_next   = {cmd.word, win_reg[15:1]};
                    count_next = count_reg + 1'b1;
                    if (count_reg == {COUNT_W{1'b1}}) begin
                        state_next = C_ROUND;
                        rnd_next   = '0;
                        v_next     = chain_reg;
                    end
                end
            end
            C_ROUND: begin
                win_next = {sched_w, win_reg[15:1]};
                v_next   = {v_reg[6:4], v_reg[3] + t1, v_reg[2:0], t1 + t2};
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == {ROUND_W{1'b1}}) begin
                    state_next = C_FINAL;
                end
            end
            C_FINAL: begin
                for (int i = 0; i < 8; i++) begin
                    chain_next[i] = chain_reg[i] + v_reg[i];
                end
                state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            count_reg <= '0;
            chain_reg <= INIT_HASH;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            chain_reg <= chain_next;
        end
        rnd_reg <= rnd_next;
        v_reg   <= v_next;
        win_reg <= win_next;
    end

    assign stat.busy  = (state_reg != C_IDLE);
    assign stat.count = count_reg;
    assign digest     = chain_reg;

endmodule

[sv/sha256_stream_hasher.sv]
// top level of the sha-256 stream hasher: input framing, padding sequencer,
// length counter and digest output buffer; depends on sha_pkg and sha_core
//
// usage:
//   s_ channel takes the message as 32-bit big-endian words, first byte in the
//   top bits. s_tuser gives the valid bytes of the word (0..4, only the last
//   word may hold fewer than 4), s_tlast marks the final word of the message.
//   m_ channel returns the eight digest words in order; m_tuser is the word
//   index and m_tlast marks the eighth word.
//   rate: a word is taken while the top sequencer and the core are both idle;
//   each sixteenth word starts a compression of 64 rounds plus one chaining
//   step in the shared round unit, and no word is taken while it runs.
//   after the last word the padding words are fed at one per cycle while
//   the core is not busy, with one or two compressions, then the digest is
//   loaded into the output buffer once the final compression ends.
//   the digest sits in its own buffer, so a new message can be streamed in
//   while the receiver stalls; a next digest waits until that buffer drains.
//   reset (aresetn low, synchronous) returns the chaining value to the
//   initial hash values and clears the counters; no clearing pass is needed.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // data_word
    input  logic [2:0]  s_tuser,   // valid_bytes
    input  logic        s_tlast,   // last_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word
    output logic [2:0]  m_tuser,   // word_index
    output logic        m_tlast    // last_of_digest
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PAD    = 5'b00010,
        S_FILL   = 5'b00100,
        S_LEN_LO = 5'b01000,
        S_WAIT   = 5'b10000
    } top_state_t;

    localparam logic [WORD_W-1:0] PAD_WORD   = 32'h8000_0000;
    localparam logic [LEN_W-1:0]  WORD_BITS  = 64'd32;
    localparam logic [2:0]        FULL_BYTES = 3'd4;
    localparam logic [COUNT_W-1:0] LEN_SLOT  = 4'd14;

    top_state_t        state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    hash_t             out_buf_reg, out_buf_next;
    logic [3:0]        out_cnt_reg, out_cnt_next;
    logic [2:0]        idx_reg, idx_next;

    core_cmd_t  cmd;
    core_stat_t stat;
    hash_t      digest;

    logic       s_accept, m_accept, load_digest;
    logic [2:0] vb;

    function automatic logic [WORD_W-1:0] tail_word(input logic [WORD_W-1:0] d,
                                                    input logic [1:0] n);
        logic [WORD_W-1:0] w;
        case (n)
            2'd0: w = 32'h8000_0000;
            2'd1: w = {d[31:24], 24'h80_0000};
            2'd2: w = {d[31:16], 16'h8000};
            default: w = {d[31:8], 8'h80};
        endcase
        return w;
    endfunction

    sha_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .digest  (digest)
    );

    assign s_tready    = (state_reg == S_IDLE) && !stat.busy;
    assign s_accept    = s_tvalid && s_tready;
    assign m_accept    = m_tvalid && m_tready;
    assign vb          = (s_tuser > FULL_BYTES) ? FULL_BYTES : s_tuser;
    assign load_digest = (state_reg == S_WAIT) && !stat.busy && (out_cnt_reg == 4'd0);

    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        cmd.push       = 1'b0;
        cmd.word       = '0;
        cmd.init_chain = load_digest;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    cmd.push = 1'b1;
                    if (!s_tlast) begin
                        cmd.word = s_tdata;
                        len_next = len_reg + WORD_BITS;
                    end else begin
                        len_next = len_reg + {58'b0, vb, 3'b000};
                        if (vb == FULL_BYTES) begin
                            cmd.word   = s_tdata;
                            state_next = S_PAD;
                        end else begin
                            cmd.word   = tail_word(s_tdata, vb[1:0]);
                            state_next = S_FILL;
                        end
                    end
                end
            end
            S_PAD: begin
                if (!stat.busy) begin
                    cmd.push   = 1'b1;
                    cmd.word   = PAD_WORD;
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                if (!stat.busy) begin
                    cmd.push = 1'b1;
                    if (stat.count == LEN_SLOT) begin
                        cmd.word   = len_reg[63:32];
                        state_next = S_LEN_LO;
                    end
                end
            end
            S_LEN_LO: begin
                if (!stat.busy) begin
                    cmd.push   = 1'b1;
                    cmd.word   = len_reg[31:0];
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (load_digest) begin
                    len_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        out_buf_next = out_buf_reg;
        out_cnt_next = out_cnt_reg;
        idx_next     = idx_reg;
        if (load_digest) begin
            out_buf_next = digest;
            out_cnt_next = 4'd8;
            idx_next     = '0;
        end else if (m_accept) begin
            out_buf_next = out_buf_reg >> WORD_W;
            out_cnt_next = out_cnt_reg - 1'b1;
            idx_next     = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            out_cnt_reg <= '0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            out_cnt_reg <= out_cnt_next;
            idx_reg     <= idx_next;
        end
        out_buf_reg <= out_buf_next;
    end

    assign m_tvalid = (out_cnt_reg != 4'd0);
    assign m_tdata  = out_buf_reg[0];
    assign m_tuser  = idx_reg;
    assign m_tlast  = (idx_reg == 3'd7);

`ifndef ASSERT_OFF
    a_block_start_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (!$past(stat.busy) && stat.busy) |-> (stat.count == 4'd0))
        else $error("compression started with a partial block");

    a_digest_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_accept && m_tlast) |=> !m_tvalid)
        else $error("digest item follows the last digest item");

    a_digest_load: assert property (@(posedge aclk) disable iff (!aresetn)
        load_digest |=> (m_tvalid && (m_tuser == 3'd0) && (state_reg == S_IDLE)))
        else $error("digest load did not start at word zero");
`endif

endmodule

[verif/sha256_stream_hasher_tb.sv]
// self-checking testbench for sha256_stream_hasher: streams messages as words and
// checks each digest word against an in-bench sha-256 model with its own state
// depends on the sha256_stream_hasher rtl and sha_pkg
module sha256_stream_hasher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int RANDOM_WORDS   = 400;
    localparam int HOLDOFF_CYCLES = 1500;
    localparam int HOLDOFF_AFTER  = 120;
    localparam int FULL_BYTES     = 4;
    localparam int BLOCK_LEN_SLOT = 14;
    localparam bit [31:0] PAD_WORD = 32'h80000000;

    localparam bit [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam bit [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct {
        bit [31:0] data_word;
        bit [2:0]  valid_bytes;
        bit        last_word;
        bit        hold_for_drain;
    } msg_word_t;

    typedef struct {
        bit [31:0] digest_word;
        bit [2:0]  word_index;
        bit        last_of_digest;
    } digest_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // data_word
    logic [2:0]  s_tuser  = '0;   // valid_bytes
    logic        s_tlast  = 1'b0; // last_word
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // digest_word
    logic [2:0]  m_tuser;         // word_index
    logic        m_tlast;         // last_of_digest

    msg_word_t    message_words[$];
    digest_item_t pending_digest_words[$];

    bit [31:0] chain_h [8];
    bit [31:0] sched_w [16];
    bit [3:0]  fill_count;
    bit [63:0] msg_bits;

    int  mismatch_count     = 0;
    int  digest_words_seen  = 0;
    int  cycle_count        = 0;
    bit  word_taken         = 1'b0;
    int  burst_left         = 0;
    int  gap_left           = 0;
    int  rx_mode            = 0;
    int  rx_stretch_left    = 0;
    int  holdoff_left       = 0;
    bit  holdoff_done       = 1'b0;

    sha256_stream_hasher dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic bit [31:0] ror(bit [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void run_rounds();
        bit [31:0] v [8];
        bit [31:0] s0, s1, ch, maj, t1, t2, x15, x2;
        v = chain_h;
        for (int t = 0; t < 64; t++) begin
            if (t >= 16) begin
                x15 = sched_w[(t - 15) & 15];
                x2  = sched_w[(t - 2) & 15];
                s0  = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
                s1  = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
                sched_w[t & 15] = sched_w[t & 15] + s0 + sched_w[(t - 7) & 15] + s1;
            end
            s1  = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
            ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1  = v[7] + s1 + ch + ROUND_K[t] + sched_w[t & 15];
            s0  = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
            maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2  = s0 + maj;
            for (int r = 7; r > 0; r--) v[r] = v[r - 1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int r = 0; r < 8; r++) chain_h[r] = chain_h[r] + v[r];
    endfunction

    function automatic void load_word(bit [31:0] w);
        sched_w[fill_count] = w;
        fill_count = fill_count + 1'b1;
        if (fill_count == 0) run_rounds();
    endfunction

    function automatic void hash_word(msg_word_t it);
        int nbytes;
        nbytes = (it.valid_bytes > FULL_BYTES) ? FULL_BYTES : it.valid_bytes;
        if (!it.last_word) begin
            msg_bits = msg_bits + 64'd32;
            load_word(it.data_word);
            return;
        end
        msg_bits = msg_bits + 64'(8 * nbytes);
        if (nbytes == FULL_BYTES) begin
            load_word(it.data_word);
            load_word(PAD_WORD);
        end else begin
            load_word((it.data_word & ~(32'hffffffff >> (8 * nbytes)))
                      | (PAD_WORD >> (8 * nbytes)));
        end
        // no room for the length field: finish this block, length goes in the next
        if (fill_count > BLOCK_LEN_SLOT) begin
            while (fill_count != 0) load_word('0);
        end
        while (fill_count < BLOCK_LEN_SLOT) load_word('0);
        load_word(msg_bits[63:32]);
        load_word(msg_bits[31:0]);
        for (int i = 0; i < 8; i++) begin
            pending_digest_words.push_back('{chain_h[i], 3'(i), i == 7});
        end
        chain_h    = IV;
        fill_count = '0;
        msg_bits   = '0;
    endfunction

    function automatic void queue_word(bit [31:0] data, bit [2:0] nbytes, bit last,
                                       bit hold);
        message_words.push_back('{data, nbytes, last, hold});
    endfunction

    // accepted input items feed the model
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            hash_word(message_words.pop_front());
            word_taken = 1'b1;
        end
    end

    // sender: bursts with gaps, optional drain before a message
    always @(negedge aclk) begin
        bit next_valid;
        next_valid = 1'b0;
        if (aresetn) begin
            if (s_tvalid && !word_taken) begin
                next_valid = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (message_words.size() > 0 &&
                         !(message_words[0].hold_for_drain &&
                           pending_digest_words.size() > 0)) begin
                next_valid = 1'b1;
                s_tdata <= message_words[0].data_word;
                s_tuser <= message_words[0].valid_bytes;
                s_tlast <= message_words[0].last_word;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        word_taken = 1'b0;
        s_tvalid <= next_valid;
    end

    // receiver: stall pattern in stretches, plus one long hold-off
    always @(negedge aclk) begin
        bit next_ready;
        next_ready = 1'b0;
        if (aresetn) begin
            if (!holdoff_done && digest_words_seen >= HOLDOFF_AFTER) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
            end else begin
                if (rx_stretch_left == 0) begin
                    rx_mode         = $urandom_range(0, 2);
                    rx_stretch_left = $urandom_range(10, 80);
                end
                rx_stretch_left--;
                case (rx_mode)
                    0: next_ready = 1'b1;
                    1: next_ready = 1'($urandom_range(0, 1));
                    default: next_ready = ($urandom_range(0, 4) == 0);
                endcase
            end
        end
        m_tready <= next_ready;
    end

    // digest checker
    always @(posedge aclk) begin
        digest_item_t exp_item;
        if (aresetn && m_tvalid && m_tready) begin
            digest_words_seen++;
            if (pending_digest_words.size() == 0) begin
                $display("%0t: unexpected digest item: actual data %h index %0d last %0b",
                         $time, m_tdata, m_tuser, m_tlast);
                mismatch_count++;
            end else begin
                exp_item = pending_digest_words.pop_front();
                if (m_tdata !== exp_item.digest_word) begin
                    $display("%0t: digest word: expected %h actual %h",
                             $time, exp_item.digest_word, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== exp_item.word_index) begin
                    $display("%0t: word index: expected %0d actual %0d",
                             $time, exp_item.word_index, m_tuser);
                    mismatch_count++;
                end
                if (m_tlast !== exp_item.last_of_digest) begin
                    $display("%0t: last flag: expected %0b actual %0b",
                             $time, exp_item.last_of_digest, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d digest items outstanding",
                     $time, pending_digest_words.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int  random_words;
        int  n;
        bit  hold;
        bit [2:0] nbytes;

        chain_h    = IV;
        fill_count = '0;
        msg_bits   = '0;

        // empty message, junk in the unused bytes
        queue_word(32'hffffffff, 3'd0, 1'b1, 1'b0);
        // three-byte message with junk in the low byte
        queue_word(32'h616263ff, 3'd3, 1'b1, 1'b0);
        // full last word, pad lands in the next word
        queue_word(32'hffffffff, 3'd4, 1'b1, 1'b0);
        // byte count above four on the last word
        queue_word(32'h00000000, 3'd7, 1'b1, 1'b0);
        queue_word(32'h80ffffff, 3'd1, 1'b1, 1'b0);
        // short byte count on a non-last word is ignored
        queue_word(32'h0000ffff, 3'd1, 1'b0, 1'b0);
        queue_word(32'hdeadbeef, 3'd2, 1'b1, 1'b0);
        // fifteen words in use after the pad, length spills into an extra block
        for (int k = 0; k < 14; k++) begin
            queue_word((k % 2) ? 32'h00000000 : 32'hffffffff,
                       (k == 5) ? 3'd5 : 3'd4, 1'b0, 1'b0);
        end
        queue_word(32'ha5a5a5a5, 3'd3, 1'b1, 1'b0);

        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            n    = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
                                                 : $urandom_range(0, 18);
            hold = (random_words == 0) || ($urandom_range(0, 11) == 0);
            for (int k = 0; k < n; k++) begin
                nbytes = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
                queue_word($urandom, nbytes, 1'b0, hold && (k == 0));
            end
            queue_word($urandom, 3'($urandom_range(0, 7)), 1'b1, hold && (n == 0));
            random_words += n + 1;
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (message_words.size() == 0);
        @(posedge aclk);
        wait (pending_digest_words.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/sha_pkg.sv
sv/sha_core.sv
sv/sha256_stream_hasher.sv
verif/sha256_stream_hasher_tb.sv
